/* sv/arppb_pkg.sv */
// shared types and constants for the pending packet buffer
// used by arppb_slot_store and arp_pending_packet_buffer_unit
package arppb_pkg;

  localparam int SLOTS    = 8;
  localparam int HW_SLOTS = (SLOTS < 8) ? SLOTS : 8;
  localparam int IDX_W    = (HW_SLOTS > 1) ? $clog2(HW_SLOTS) : 1;
  localparam int SLOT_W   = 3;
  localparam int HANDLE_W = 16;
  localparam int HOP_W    = 32;
  localparam int TIME_W   = 32;
  localparam int ATT_W    = 8;
  localparam int MASK_W   = 8;
  localparam int ACT_W    = 2;
  localparam int IN_DATA_W  = 88;
  localparam int OUT_DATA_W = 56;

  localparam logic [ACT_W-1:0] ACT_SEND    = 2'd0;
  localparam logic [ACT_W-1:0] ACT_FAIL    = 2'd1;
  localparam logic [ACT_W-1:0] ACT_REQUEST = 2'd2;
  localparam logic [ACT_W-1:0] ACT_STORED  = 2'd3;

  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_CHECK  = 1'b1;

  localparam logic [ATT_W-1:0] ATT_MAX = {ATT_W{1'b1}};

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_INS_SCAN,
    ST_INS_EVICT,
    ST_INS_STORE,
    ST_CHK_SCAN
  } state_t;

  typedef struct packed {
    logic             store;
    logic             release_slot;
    logic             bump;
    logic [IDX_W-1:0] idx;
  } slot_cmd_t;

endpackage

/* sv/arppb_slot_store.sv */
// slot storage: valid bits, attempt counts, handles, next hops, time stamps
// one read port, one update command per cycle; depends on arppb_pkg
module arppb_slot_store
  import arppb_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  slot_cmd_t           cmd,
  input  logic [HANDLE_W-1:0] wr_handle,
  input  logic [HOP_W-1:0]    wr_hop,
  input  logic [TIME_W-1:0]   wr_time,
  input  logic [IDX_W-1:0]    rd_idx,
  output logic [HANDLE_W-1:0] rd_handle,
  output logic [HOP_W-1:0]    rd_hop,
  output logic [TIME_W-1:0]   rd_time,
  output logic [ATT_W-1:0]    rd_attempts,
  output logic [HW_SLOTS-1:0] valid
);

  logic [HANDLE_W-1:0] handle_arr   [HW_SLOTS];
  logic [HOP_W-1:0]    hop_arr      [HW_SLOTS];
  logic [TIME_W-1:0]   time_arr     [HW_SLOTS];
  logic [ATT_W-1:0]    attempts_arr [HW_SLOTS];

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
      for (int i = 0; i < HW_SLOTS; i++) begin
        attempts_arr[i] <= '0;
      end
    end else begin
      if (cmd.store) begin
        valid[cmd.idx]        <= 1'b1;
        attempts_arr[cmd.idx] <= ATT_W'(1);
      end else if (cmd.release_slot) begin
        valid[cmd.idx] <= 1'b0;
      end else if (cmd.bump && attempts_arr[cmd.idx] != ATT_MAX) begin
        attempts_arr[cmd.idx] <= attempts_arr[cmd.idx] + ATT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.store) begin
      handle_arr[cmd.idx] <= wr_handle;
      hop_arr[cmd.idx]    <= wr_hop;
      time_arr[cmd.idx]   <= wr_time;
    end
  end

  assign rd_handle   = handle_arr[rd_idx];
  assign rd_hop      = hop_arr[rd_idx];
  assign rd_time     = time_arr[rd_idx];
  assign rd_attempts = attempts_arr[rd_idx];

endmodule

/* sv/arp_pending_packet_buffer_unit.sv */
// pending packet buffer: holds packets waiting for address resolution
// depends on arppb_pkg and arppb_slot_store
//
// s_* channel takes one command per transfer: s_tuser is the op (0 insert,
// 1 check), s_tdata carries handle, next hop, time stamp and resolved mask.
// m_* channel returns result transfers: m_tuser is the action, m_tlast marks
// the final result of a command.
// an insert scans slots one per cycle through a single 32-bit age compare,
// stopping at the first free slot, and gives an eviction result first
// when all 8 slots are full.
// a check visits all 8 slots, one per cycle when the receiver keeps up, and
// emits one result per occupied slot; an empty buffer gives no result.
// s_tready is high only between commands; the next command is taken the
// cycle after the previous one finishes.
// results sit in one output register; while it holds a result not yet taken
// the scan waits on the slot that has a result to give, and resumes once the register frees.
// max_attempts is written through cfg_wr_en/cfg_wr_data, reset value 3.
// reset empties every slot and clears the attempt counts.
module arp_pending_packet_buffer_unit
  import arppb_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  // [15:0] handle, [47:16] hop_addr, [79:48] now, [87:80] resolved_mask
  input  logic [IN_DATA_W-1:0]  s_tdata,
  // [0] op
  input  logic                  s_tuser,
  output logic                  m_tvalid,
  input  logic                  m_tready,
  // [15:0] out_handle, [47:16] out_hop_addr, [50:48] slot, [55:51] zero
  output logic [OUT_DATA_W-1:0] m_tdata,
  // [1:0] action
  output logic [ACT_W-1:0]      m_tuser,
  output logic                  m_tlast,
  input  logic                  cfg_wr_en,
  input  logic [ATT_W-1:0]      cfg_wr_data
);

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(HW_SLOTS - 1);

  state_t              state, state_next;
  logic [IDX_W-1:0]    idx, idx_next;
  logic [IDX_W-1:0]    victim, victim_next;
  logic [TIME_W-1:0]   best_time, best_time_next;
  logic [ATT_W-1:0]    max_attempts;

  logic [HANDLE_W-1:0] handle_q;
  logic [HOP_W-1:0]    hop_q;
  logic [TIME_W-1:0]   now_q;
  logic [MASK_W-1:0]   mask_q;

  slot_cmd_t           cmd;
  logic [IDX_W-1:0]    rd_idx;
  logic [HANDLE_W-1:0] rd_handle;
  logic [HOP_W-1:0]    rd_hop;
  logic [TIME_W-1:0]   rd_time;
  logic [ATT_W-1:0]    rd_attempts;
  logic [HW_SLOTS-1:0] valid;
  logic [HW_SLOTS-1:0] valid_above;

  logic                out_free;
  logic                emit;
  logic [ACT_W-1:0]    emit_act;
  logic [HANDLE_W-1:0] emit_handle;
  logic [HOP_W-1:0]    emit_hop;
  logic [IDX_W-1:0]    emit_slot;
  logic                emit_last;

  arppb_slot_store u_store (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .wr_handle   (handle_q),
    .wr_hop      (hop_q),
    .wr_time     (now_q),
    .rd_idx      (rd_idx),
    .rd_handle   (rd_handle),
    .rd_hop      (rd_hop),
    .rd_time     (rd_time),
    .rd_attempts (rd_attempts),
    .valid       (valid)
  );

  assign s_tready    = (state == ST_IDLE);
  assign out_free    = !m_tvalid || m_tready;
  assign rd_idx      = (state == ST_INS_EVICT) ? victim : idx;
  assign valid_above = valid >> idx;

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      idx          <= '0;
      victim       <= '0;
      max_attempts <= ATT_W'(3);
    end else begin
      state  <= state_next;
      idx    <= idx_next;
      victim <= victim_next;
      if (cfg_wr_en) begin
        max_attempts <= cfg_wr_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    best_time <= best_time_next;
    if (s_tvalid && s_tready) begin
      handle_q <= s_tdata[15:0];
      hop_q    <= s_tdata[47:16];
      now_q    <= s_tdata[79:48];
      mask_q   <= s_tdata[87:80];
    end
  end

  always_comb begin
    state_next     = state;
    idx_next       = idx;
    victim_next    = victim;
    best_time_next = best_time;
    cmd            = '0;
    emit           = 1'b0;
    emit_act       = ACT_STORED;
    emit_handle    = rd_handle;
    emit_hop       = rd_hop;
    emit_slot      = idx;
    emit_last      = 1'b0;
    case (state)
      ST_IDLE: begin
        idx_next = '0;
        if (s_tvalid) begin
          state_next = (s_tuser == OP_CHECK) ? ST_CHK_SCAN : ST_INS_SCAN;
        end
      end
      ST_INS_SCAN: begin
        if (!valid[idx]) begin
          victim_next = idx;
          state_next  = ST_INS_STORE;
        end else begin
          // oldest search, earlier index kept on equal time stamps
          if (idx == '0 || rd_time < best_time) begin
            victim_next    = idx;
            best_time_next = rd_time;
          end
          if (idx == LAST_IDX) begin
            state_next = ST_INS_EVICT;
          end else begin
            idx_next = idx + IDX_W'(1);
          end
        end
      end
      ST_INS_EVICT: begin
        if (out_free) begin
          emit       = 1'b1;
          emit_act   = mask_q[victim] ? ACT_SEND : ACT_FAIL;
          emit_slot  = victim;
          state_next = ST_INS_STORE;
        end
      end
      ST_INS_STORE: begin
        if (out_free) begin
          emit        = 1'b1;
          emit_act    = ACT_STORED;
          emit_handle = handle_q;
          emit_hop    = hop_q;
          emit_slot   = victim;
          emit_last   = 1'b1;
          cmd.store   = 1'b1;
          cmd.idx     = victim;
          state_next  = ST_IDLE;
        end
      end
      ST_CHK_SCAN: begin
        if (!valid[idx] || out_free) begin
          if (valid[idx]) begin
            emit      = 1'b1;
            cmd.idx   = idx;
            // last result when no occupied slot follows this one
            emit_last = ((valid_above >> 1) == '0);
            if (mask_q[idx]) begin
              emit_act         = ACT_SEND;
              cmd.release_slot = 1'b1;
            end else if (rd_attempts > max_attempts) begin
              emit_act         = ACT_FAIL;
              cmd.release_slot = 1'b1;
            end else begin
              emit_act = ACT_REQUEST;
              cmd.bump = 1'b1;
            end
          end
          if (idx == LAST_IDX) begin
            state_next = ST_IDLE;
          end else begin
            idx_next = idx + IDX_W'(1);
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (emit) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      m_tdata <= {5'b0, SLOT_W'(emit_slot), emit_hop, emit_handle};
      m_tuser <= emit_act;
      m_tlast <= emit_last;
    end
  end

endmodule
